FILE: src/cpr_pkg.sv
// shared types and constants of the clock page replacement block
`default_nettype none
package cpr_pkg;

    localparam int SLOTS_DEF        = 16;
    localparam int PAGE_ID_BITS_DEF = 20;

    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_INSERTED = 2'd0;
    localparam t_status ST_VICTIM   = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_EVICT  = 1'b1;

endpackage
`default_nettype wire

FILE: src/cpr_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: src/clock_page_replacement.sv
// top level of the clock (second chance) page replacement ring
`default_nettype none
// Tracks up to SLOTS pages in a ring ordered oldest to newest, each with a
// visited bit, plus a clock hand. A request with tuser 0 inserts the page in
// tdata; tuser 1 asks for a victim. Every request gives exactly one result:
// tuser carries the status (0 inserted, 1 victim, 2 ring empty, 3 ring full),
// tdata the victim page or zero. One request is worked on at a time; the next
// is taken once the result sits in the output register. An eviction passes
// at most SLOTS visited pages, and each sweep step is one read and one check
// of the slot memory. Slot data, ring links and the free slot stack live in
// synchronous memories; there is no clearing pass after reset.
module clock_page_replacement #(
    parameter int SLOTS        = cpr_pkg::SLOTS_DEF,
    parameter int PAGE_ID_BITS = cpr_pkg::PAGE_ID_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // page_id
    input  wire logic [((PAGE_ID_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // victim_page
    output logic [((PAGE_ID_BITS+7)/8)*8-1:0]  m_axis_tdata,
    // status
    output cpr_pkg::t_status                   m_axis_tuser
);

    import cpr_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DATA_W = ((PAGE_ID_BITS + 7) / 8) * 8;
    localparam int ENT_W  = PAGE_ID_BITS + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS,
        S_RD,
        S_CHK
    } t_state;

    t_state r_state, n_state;
    logic                    r_op, n_op;
    logic [PAGE_ID_BITS-1:0] r_id, n_id;
    logic [IDX_W-1:0]        r_cur, n_cur;
    logic [IDX_W-1:0]        r_oldest, n_oldest;
    logic [IDX_W-1:0]        r_newest, n_newest;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [IDX_W-1:0]        r_hand, n_hand;
    logic                    r_at_head, n_at_head;
    logic [CNT_W-1:0]        r_fresh, n_fresh;
    logic [CNT_W-1:0]        r_free_top, n_free_top;
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [PAGE_ID_BITS-1:0] r_out_victim;

    logic                    post;
    t_status                 post_status;
    logic [PAGE_ID_BITS-1:0] post_victim;
    logic                    out_free;

    logic                    ent_we, ent_re;
    logic [IDX_W-1:0]        ent_waddr;
    logic [ENT_W-1:0]        ent_wdata, ent_rdata;
    logic                    nl_we, ol_we;
    logic [IDX_W-1:0]        nl_waddr, ol_waddr, nl_wdata, ol_wdata;
    logic [IDX_W-1:0]        nl_rdata, ol_rdata;
    logic                    fr_we, fr_re;
    logic [IDX_W-1:0]        fr_rdata, fr_raddr;
    logic [CNT_W-1:0]        free_top_dec;
    logic [IDX_W-1:0]        ins_slot;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = DATA_W'(r_out_victim);
    assign free_top_dec  = r_free_top - CNT_W'(1);
    assign fr_raddr      = free_top_dec[IDX_W-1:0];
    assign ins_slot      = (r_fresh != FULL_CNT) ? r_fresh[IDX_W-1:0] : fr_rdata;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_cur       = r_cur;
        n_oldest    = r_oldest;
        n_newest    = r_newest;
        n_count     = r_count;
        n_hand      = r_hand;
        n_at_head   = r_at_head;
        n_fresh     = r_fresh;
        n_free_top  = r_free_top;
        post        = 1'b0;
        post_status = ST_INSERTED;
        post_victim = '0;
        ent_we      = 1'b0;
        ent_re      = 1'b0;
        ent_waddr   = r_cur;
        ent_wdata   = {1'b0, ent_rdata[PAGE_ID_BITS-1:0]};
        nl_we       = 1'b0;
        nl_waddr    = ol_rdata;
        nl_wdata    = nl_rdata;
        ol_we       = 1'b0;
        ol_waddr    = nl_rdata;
        ol_wdata    = ol_rdata;
        fr_we       = 1'b0;
        fr_re       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op    = s_axis_tuser;
                    n_id    = s_axis_tdata[PAGE_ID_BITS-1:0];
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_op == OP_INSERT) begin
                    if (r_count == FULL_CNT) begin
                        if (out_free) begin
                            post        = 1'b1;
                            post_status = ST_FULL;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        fr_re   = (r_fresh == FULL_CNT);
                        n_state = S_INS;
                    end
                end else begin
                    if (r_count == '0) begin
                        if (out_free) begin
                            post        = 1'b1;
                            post_status = ST_EMPTY;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        n_cur   = r_at_head ? r_oldest : r_hand;
                        n_state = S_RD;
                    end
                end
            end
            S_INS: begin
                if (out_free) begin
                    post        = 1'b1;
                    post_status = ST_INSERTED;
                    ent_we      = 1'b1;
                    ent_waddr   = ins_slot;
                    ent_wdata   = {1'b1, r_id};
                    if (r_count != '0) begin
                        nl_we    = 1'b1;
                        nl_waddr = r_newest;
                        nl_wdata = ins_slot;
                        ol_we    = 1'b1;
                        ol_waddr = ins_slot;
                        ol_wdata = r_newest;
                    end else begin
                        n_oldest = ins_slot;
                    end
                    n_newest = ins_slot;
                    n_count  = r_count + CNT_W'(1);
                    if (r_fresh != FULL_CNT) begin
                        n_fresh = r_fresh + CNT_W'(1);
                    end else begin
                        n_free_top = free_top_dec;
                    end
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                ent_re  = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (ent_rdata[PAGE_ID_BITS]) begin
                    ent_we  = 1'b1;
                    n_cur   = (r_cur == r_newest) ? r_oldest : nl_rdata;
                    n_state = S_RD;
                end else if (out_free) begin
                    post        = 1'b1;
                    post_status = ST_VICTIM;
                    post_victim = ent_rdata[PAGE_ID_BITS-1:0];
                    if (r_cur == r_newest) begin
                        n_at_head = 1'b1;
                    end else begin
                        n_hand    = nl_rdata;
                        n_at_head = 1'b0;
                    end
                    if (r_count > CNT_W'(1)) begin
                        if (r_cur == r_oldest) begin
                            n_oldest = nl_rdata;
                        end else begin
                            nl_we = 1'b1;
                        end
                        if (r_cur == r_newest) begin
                            n_newest = ol_rdata;
                        end else begin
                            ol_we = 1'b1;
                        end
                    end
                    fr_we      = 1'b1;
                    n_free_top = r_free_top + CNT_W'(1);
                    n_count    = r_count - CNT_W'(1);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_newest    <= '0;
            r_count     <= '0;
            r_hand      <= '0;
            r_at_head   <= 1'b1;
            r_fresh     <= '0;
            r_free_top  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_oldest   <= n_oldest;
            r_newest   <= n_newest;
            r_count    <= n_count;
            r_hand     <= n_hand;
            r_at_head  <= n_at_head;
            r_fresh    <= n_fresh;
            r_free_top <= n_free_top;
            if (post) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_op  <= n_op;
        r_id  <= n_id;
        r_cur <= n_cur;
        if (post) begin
            r_out_status <= post_status;
            r_out_victim <= post_victim;
        end
    end

    // visited bit above the page id
    cpr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ent_we),
        .i_wr_addr (ent_waddr),
        .i_wr_data (ent_wdata),
        .i_rd_en   (ent_re),
        .i_rd_addr (r_cur),
        .o_rd_data (ent_rdata)
    );

    cpr_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_newer_ram (
        .i_clk     (i_clk),
        .i_wr_en   (nl_we),
        .i_wr_addr (nl_waddr),
        .i_wr_data (nl_wdata),
        .i_rd_en   (ent_re),
        .i_rd_addr (r_cur),
        .o_rd_data (nl_rdata)
    );

    cpr_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_older_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ol_we),
        .i_wr_addr (ol_waddr),
        .i_wr_data (ol_wdata),
        .i_rd_en   (ent_re),
        .i_rd_addr (r_cur),
        .o_rd_data (ol_rdata)
    );

    // stack of released slots
    cpr_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_free_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fr_we),
        .i_wr_addr (r_free_top[IDX_W-1:0]),
        .i_wr_data (r_cur),
        .i_rd_en   (fr_re),
        .i_rd_addr (fr_raddr),
        .o_rd_data (fr_rdata)
    );

endmodule
`default_nettype wire
